/* hw/rtl/esba_pkg.sv */
// Shared types and constants of the even-spread block allocator.
package esba_pkg;

  localparam int DATA_W    = 16;
  localparam int NODE_W    = 6;
  localparam int DIV_STEPS = 2;
  localparam int DIV_CNT_W = 1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_LOAD  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] request_blocks;
    logic [NODE_W-1:0] node_select;
    logic [DATA_W-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [NODE_W-1:0] short_node;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic mem_rd;
    logic idx_clr;
    logic idx_inc;
    logic upd_wr;
    logic load_wr;
    logic mark_refuse;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic idx_last;
    logic short_hit;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/esba_ctrl.sv */
// Controller state machine that sequences load, division, check and update passes.
module esba_ctrl
  import esba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_load,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_load ? ST_LOAD : ST_DIV;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_RESP;
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        state_nxt = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (sts.short_hit) begin
          state_nxt = ST_RESP;
        end else if (sts.idx_last) begin
          state_nxt = ST_UPD_RD;
        end else begin
          state_nxt = ST_CHK_RD;
        end
      end
      ST_UPD_RD: begin
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        state_nxt = sts.idx_last ? ST_RESP : ST_UPD_RD;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_CHK_RD: begin
        cmd.mem_rd = 1'b1;
      end
      ST_CHK_CMP: begin
        if (sts.short_hit) begin
          cmd.mark_refuse = 1'b1;
        end else if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_UPD_RD: begin
        cmd.mem_rd = 1'b1;
      end
      ST_UPD_WR: begin
        cmd.upd_wr  = 1'b1;
        cmd.idx_inc = !sts.idx_last;
      end
      ST_RESP: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/esba_dp.sv */
// Datapath: free-count memory, reciprocal divider, share compare and result register.
module esba_dp
  import esba_pkg::*;
#(
  parameter int NODE_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int RW = $clog2(NODE_COUNT) + 1;
  localparam int SH = DATA_W + $clog2(NODE_COUNT);
  localparam int MW = DATA_W + 2;
  localparam int PW = DATA_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'((longint'(1) << SH) / longint'(NODE_COUNT) + longint'(1));

  in_item_t            item_r;
  logic [DATA_W-1:0]   quo_r;
  logic [RW-1:0]       rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [IW-1:0]       idx_r;
  logic [DATA_W-1:0]   mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] vld_r;
  logic [DATA_W-1:0]   rd_data_r;
  logic                rd_vld_r;
  logic                res_status_r;
  logic [NODE_W-1:0]   res_node_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic [PW-1:0]       quo_prod;
  logic [DATA_W-1:0]   quo_back;
  logic [DATA_W:0]     share;
  logic [DATA_W-1:0]   node_val;
  logic                sel_ok;
  logic [IW-1:0]       wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                wr_en;

  assign quo_prod = PW'(item_r.request_blocks) * PW'(RECIP);
  assign quo_back = quo_r * DATA_W'(NODE_COUNT);
  assign share    = (DATA_W+1)'(quo_r) + (DATA_W+1)'(RW'(idx_r) < rem_r);
  assign node_val = rd_vld_r ? rd_data_r : '0;
  assign sel_ok   = (NODE_W+1)'(item_r.node_select) < (NODE_W+1)'(NODE_COUNT);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = DATA_W'((DATA_W+1)'(node_val) - share);
    if (cmd.load_wr) begin
      wr_en   = sel_ok;
      wr_addr = item_r.node_select[IW-1:0];
      wr_data = item_r.load_value;
    end else if (cmd.upd_wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r     <= '0;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.capture) begin
      quo_r     <= '0;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (div_cnt_r == '0) begin
        quo_r <= DATA_W'(quo_prod >> SH);
      end else begin
        rem_r <= RW'(item_r.request_blocks - quo_back);
      end
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.capture || cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.mem_rd) begin
        rd_vld_r <= vld_r[idx_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_status_r <= STATUS_OK;
      res_node_r   <= '0;
    end else if (cmd.capture) begin
      res_status_r <= STATUS_OK;
      res_node_r   <= '0;
    end else if (cmd.mark_refuse) begin
      res_status_r <= STATUS_REFUSED;
      res_node_r   <= NODE_W'(idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status     <= res_status_r;
      out_r.short_node <= res_node_r;
    end
  end

  assign sts.div_last  = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts.idx_last  = idx_r == IW'(NODE_COUNT - 1);
  assign sts.short_hit = (DATA_W+1)'(node_val) < share;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // The remainder of the divider never reaches the node count.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < RW'(NODE_COUNT))
    else $error("divider remainder out of range");

  // A refused item names a node that exists.
  a_short_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == STATUS_REFUSED)
      |-> (NODE_W+1)'(out_r.short_node) < (NODE_W+1)'(NODE_COUNT))
    else $error("refused item names a missing node");

  // A granted or loaded item carries node zero.
  a_grant_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == STATUS_OK) |-> out_r.short_node == '0)
    else $error("granted item carries a nonzero node");

  // In the update pass, counts are only rewritten after a read of the same node.
  a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_wr |-> $past(cmd.mem_rd))
    else $error("update write without a preceding read");

endmodule

/* hw/rtl/even_spread_block_allocator_unit.sv */
// Top level of the even-spread block allocator: controller, datapath and ports.
// A load writes an in-range node's count, then shows its result; an item is taken only once the last result is out.
// An allocate item runs the reciprocal division (quotient, then remainder), then a check pass that
// reads and compares each node and, when granted, an update pass that reads and rewrites each node.
// A refusal at node j ends the check pass and gives its result; a waiting result holds the block.
// Reset (rst_n low, synchronous) clears every node count to zero through per-node valid bits.
module even_spread_block_allocator_unit
  import esba_pkg::*;
#(
  parameter int NODE_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  cmd_t cmd;
  sts_t sts;

  esba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_load  (in_item.mode == MODE_LOAD),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  esba_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* tb/sv/esba_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the even-spread block allocator: predicts each result and compares it.
module esba_result_checker
  import esba_pkg::*;
#(
  parameter int NODE_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending,
  output int        grant_count,
  output int        refuse_count,
  output int        load_count
);

  logic [DATA_W-1:0] free_count [NODE_COUNT];
  out_item_t         awaited_results [$];
  int                errors;
  int                grants;
  int                refusals;
  int                loads;

  function automatic out_item_t allocate_evenly(input in_item_t item);
    out_item_t res;
    int        portion [NODE_COUNT];
    bit        short_found;
    res = '0;
    short_found = 1'b0;
    if (item.mode == MODE_LOAD) begin
      if (item.node_select < NODE_COUNT) begin
        free_count[item.node_select] = item.load_value;
      end
      loads++;
      return res;
    end
    for (int n = 0; n < NODE_COUNT; n++) begin
      portion[n] = item.request_blocks / NODE_COUNT +
                   ((n < item.request_blocks % NODE_COUNT) ? 1 : 0);
      if (!short_found && free_count[n] < portion[n]) begin
        short_found = 1'b1;
        res.status = STATUS_REFUSED;
        res.short_node = NODE_W'(n);
      end
    end
    if (short_found) begin
      refusals++;
    end else begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        free_count[n] = free_count[n] - DATA_W'(portion[n]);
      end
      grants++;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (free_count[n]) begin
        free_count[n] = '0;
      end
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited, actual status=%0b short_node=%0d",
                   $time, out_item.status, out_item.short_node);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status mismatch, expected %0b, actual %0b",
                     $time, want.status, out_item.status);
            errors++;
          end
          if (out_item.short_node !== want.short_node) begin
            $display("%0t: short_node mismatch, expected %0d, actual %0d",
                     $time, want.short_node, out_item.short_node);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(allocate_evenly(in_item));
      end
    end
    fail_count   <= errors;
    pending      <= awaited_results.size();
    grant_count  <= grants;
    refuse_count <= refusals;
    load_count   <= loads;
  end

endmodule

/* tb/sv/tb_even_spread_block_allocator_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the even-spread block allocator: stimulus, idling, watchdog and verdict.
module tb_even_spread_block_allocator_unit
  import esba_pkg::*;
();

  localparam int NODE_COUNT   = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 370;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int pending;
  int grant_count;
  int refuse_count;
  int load_count;
  int send_pct     = 31;
  int recv_pct     = 71;
  int hold_asked   = 0;
  int hold_done    = 0;
  int quiet_cycles = 0;
  int sent         = 0;

  even_spread_block_allocator_unit #(
    .NODE_COUNT(NODE_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  esba_result_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .pending     (pending),
    .grant_count (grant_count),
    .refuse_count(refuse_count),
    .load_count  (load_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    forever begin
      if (hold_asked != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end
      out_ready <= ($urandom_range(99) >= recv_pct);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("even_spread_block_allocator_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_load(input int node, input logic [DATA_W-1:0] value);
    in_item_t item;
    item.mode           = MODE_LOAD;
    item.request_blocks = DATA_W'($urandom);
    item.node_select    = NODE_W'(node);
    item.load_value     = value;
    return item;
  endfunction

  function automatic in_item_t make_alloc(input logic [DATA_W-1:0] blocks);
    in_item_t item;
    item.mode           = MODE_ALLOC;
    item.request_blocks = blocks;
    item.node_select    = NODE_W'($urandom);
    item.load_value     = DATA_W'($urandom);
    return item;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 60) return DATA_W'($urandom_range(0, 2000));
    return DATA_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_request();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return DATA_W'($urandom_range(0, 15));
    if (roll < 60) return DATA_W'($urandom_range(0, 8000));
    if (roll < 85) return DATA_W'($urandom);
    return DATA_W'(NODE_COUNT * $urandom_range(0, 500) + $urandom_range(0, NODE_COUNT - 1));
  endfunction

  task automatic offer(input in_item_t item);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_burst();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        offer(make_load(n, pick_value()));
      end
      repeat ($urandom_range(1, 8)) offer(make_alloc(pick_request()));
    end else if (roll < 85) begin
      repeat ($urandom_range(1, 3)) offer(make_load($urandom_range(0, NODE_COUNT - 1),
                                                    pick_value()));
      repeat ($urandom_range(1, 5)) offer(make_alloc(pick_request()));
    end else begin
      repeat ($urandom_range(1, 6)) offer(in_item_t'({$urandom, $urandom}));
    end
    if ($urandom_range(99) < 10) begin
      drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    offer(make_alloc(16'd0));
    offer(make_alloc(16'd1));
    for (int n = 0; n < NODE_COUNT; n++) begin
      offer(make_load(n, 16'hFFFF));
    end
    offer('{mode: MODE_LOAD, request_blocks: 16'hFFFF, node_select: 6'd63, load_value: 16'h0});
    offer(make_load(NODE_COUNT, 16'h1234));
    offer(make_alloc(16'hFFFF));
    offer(make_alloc(16'd7));
    offer(make_load(3, 16'h0));
    offer(make_alloc(16'd8));
    offer(make_alloc(16'd3));
    offer('{mode: MODE_ALLOC, request_blocks: 16'hFFFF, node_select: 6'd63,
            load_value: 16'hFFFF});
    offer(make_load(0, 16'h0));
    offer(make_alloc(16'd1));
    offer(make_load(NODE_COUNT - 1, 16'h0));
    offer(make_alloc(16'd7));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_pct = (phase == 0) ? 31 : (phase == 1) ? 71 : 0;
      recv_pct = (phase == 0) ? 71 : (phase == 1) ? 31 : 0;
      if (phase == 2) begin
        hold_asked++;
        for (int n = 0; n < NODE_COUNT; n++) begin
          offer(make_load(n, DATA_W'($urandom)));
        end
        repeat (24) offer(make_alloc(DATA_W'($urandom_range(0, 4000))));
        drain();
      end
      while (sent < PHASE_ITEMS * (phase + 1) + 25) begin
        random_burst();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d items: %0d loads, %0d granted and %0d refused allocations.",
             sent, load_count, grant_count, refuse_count);
    $display("Idling mixes 31/71, 71/31 and none, plus one output stall of %0d cycles.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("even_spread_block_allocator_unit test passed");
    end else begin
      $display("even_spread_block_allocator_unit test failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/esba_pkg.sv
hw/rtl/esba_ctrl.sv
hw/rtl/esba_dp.sv
hw/rtl/even_spread_block_allocator_unit.sv
tb/sv/esba_result_checker.sv
tb/sv/tb_even_spread_block_allocator_unit.sv
